// ===== rtl/sqi_pkg.sv =====
`default_nettype none

package sqi_pkg;

    // default sizes of the store
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths on the stream ports
    localparam int CMD_W     = 2;
    localparam int IN_KEY_W  = 32;
    localparam int RANK_W    = 4;
    localparam int OUT_KEY_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;
    localparam int M_USER_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } sqi_cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } sqi_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sqi_cell.sv =====
`default_nettype none

module sqi_cell #(
    parameter int KEY_WIDTH = sqi_pkg::KEY_WIDTH_DEF
) (
    input  wire                  clk,
    input  sqi_pkg::sqi_ctrl_t   ctrl,
    input  wire  [KEY_WIDTH-1:0] new_key,
    input  wire                  occupied,   // cell index below entry count
    input  wire                  tail,       // cell index equals entry count
    input  wire                  left_gt,
    input  wire  [KEY_WIDTH-1:0] left_key,
    input  wire  [KEY_WIDTH-1:0] right_key,
    output logic                 gt,
    output logic [KEY_WIDTH-1:0] key
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    assign gt  = occupied && (key_reg > new_key);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.insert)
        begin
            // neighbor below moves up, first greater or first free slot takes the key
            if (left_gt)
                key_next = left_key;
            else if (gt || tail)
                key_next = new_key;
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_queue.sv =====
`default_nettype none

// channel   dir  tdata (low bit up)                      tuser (low bit up)
// s_*       in   key[31:0], rank[35:32], zero fill       command[1:0]
// m_*       out  out_key[31:0], count[36:32], zero fill  found[0], status[2:1]
//
// the row of compare-and-shift cells updates the whole store in the cycle
// the request is accepted, and the response is registered for the next cycle
// a new request is taken while the response register is empty or being drained
// reset clears the entry count and the response valid; cell contents are
// left as they are and only cells below the count are ever read
// a stalled m_tready holds the response and stops further requests

module sorted_insert_queue #(
    parameter int DEPTH     = sqi_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sqi_pkg::KEY_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [sqi_pkg::S_DATA_W-1:0]  s_tdata,   // key, rank
    input  wire  [sqi_pkg::CMD_W-1:0]     s_tuser,   // command
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [sqi_pkg::M_DATA_W-1:0]  m_tdata,   // out_key, count
    output logic [sqi_pkg::M_USER_W-1:0]  m_tuser    // found, status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > sqi_pkg::RANK_W) ? CNT_W : sqi_pkg::RANK_W;

    // request fields
    sqi_pkg::sqi_cmd_t                 cmd;
    logic [sqi_pkg::IN_KEY_W-1:0]      in_key;
    logic [sqi_pkg::RANK_W-1:0]        in_rank;
    logic [KEY_WIDTH-1:0]              new_key;
    logic                              fire;

    // store control
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              full;
    logic                              empty;
    logic                              rank_ok;
    logic [CMP_W-1:0]                  rank_x;
    logic [CMP_W-1:0]                  count_x;
    sqi_pkg::sqi_ctrl_t                ctrl;

    // cell row
    logic [DEPTH-1:0]                  gt;
    logic [KEY_WIDTH-1:0]              keys [DEPTH];

    // response register
    logic                              valid_reg;
    logic [sqi_pkg::OUT_KEY_W-1:0]     out_key_reg;
    logic                              found_reg;
    logic [sqi_pkg::STATUS_W-1:0]      status_reg;
    logic [sqi_pkg::COUNT_W-1:0]       count_out_reg;
    logic [sqi_pkg::OUT_KEY_W-1:0]     out_key_next;
    logic                              found_next;
    logic [sqi_pkg::STATUS_W-1:0]      status_next;

    assign cmd     = sqi_pkg::sqi_cmd_t'(s_tuser);
    assign in_key  = s_tdata[sqi_pkg::IN_KEY_W-1:0];
    assign in_rank = s_tdata[sqi_pkg::IN_KEY_W +: sqi_pkg::RANK_W];
    assign new_key = KEY_WIDTH'(in_key);

    assign s_tready = !valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rank_x  = CMP_W'(in_rank);
    assign count_x = CMP_W'(count_reg);
    assign rank_ok = (rank_x < count_x);

    always_comb
    begin
        ctrl         = '0;
        count_next   = count_reg;
        out_key_next = '0;
        found_next   = 1'b0;
        status_next  = sqi_pkg::ST_OK;
        case (cmd)
            sqi_pkg::CMD_INSERT:
            begin
                if (full)
                    status_next = sqi_pkg::ST_FULL;
                else
                begin
                    ctrl.insert = fire;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            sqi_pkg::CMD_POP:
            begin
                if (empty)
                    status_next = sqi_pkg::ST_EMPTY;
                else
                begin
                    ctrl.pop     = fire;
                    count_next   = count_reg - CNT_W'(1);
                    out_key_next = sqi_pkg::OUT_KEY_W'(keys[0]);
                    found_next   = 1'b1;
                end
            end
            sqi_pkg::CMD_GET:
            begin
                if (!rank_ok)
                    status_next = sqi_pkg::ST_EMPTY;
                else
                begin
                    out_key_next = sqi_pkg::OUT_KEY_W'(keys[rank_x[IDX_W-1:0]]);
                    found_next   = 1'b1;
                end
            end
            sqi_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // row of cells, each handing its key up or down the chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 left_gt;
        logic [KEY_WIDTH-1:0] left_key;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_gt  = 1'b0;
            assign left_key = new_key;
        end
        else
        begin : g_mid
            assign left_gt  = gt[i-1];
            assign left_key = keys[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            // top slot frees up on pop, its new content is never read
            assign right_key = keys[i];
        end
        else
        begin : g_inner
            assign right_key = keys[i+1];
        end

        sqi_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_key   (new_key),
            .occupied  (CNT_W'(i) < count_reg),
            .tail      (CNT_W'(i) == count_reg),
            .left_gt   (left_gt),
            .left_key  (left_key),
            .right_key (right_key),
            .gt        (gt[i]),
            .key       (keys[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // response payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_key_reg   <= out_key_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            count_out_reg <= sqi_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(sqi_pkg::M_DATA_W - sqi_pkg::OUT_KEY_W - sqi_pkg::COUNT_W){1'b0}},
                       count_out_reg, out_key_reg};
    assign m_tuser  = {status_reg, found_reg};

endmodule

`default_nettype wire

// ===== dv/sorted_insert_queue_tb.sv =====
`timescale 1ns / 100ps

module sorted_insert_queue_tb;

    localparam int STORE_DEPTH    = sqi_pkg::DEPTH_DEF;
    localparam int RANDOM_COUNT   = 925;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int FILL_BITS      = sqi_pkg::S_DATA_W - sqi_pkg::IN_KEY_W - sqi_pkg::RANK_W;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} gen_phase_t;

    typedef enum int {RDY_OPEN, RDY_RANDOM, RDY_THROTTLE} ready_mode_t;

    // one request as the sender holds it; hold_until_idle makes the sender
    // wait for every outstanding response before this request goes out
    typedef struct packed {
        logic                           hold_until_idle;
        sqi_pkg::sqi_cmd_t              cmd;
        logic [sqi_pkg::IN_KEY_W-1:0]   key;
        logic [sqi_pkg::RANK_W-1:0]     rank;
    } queue_req_t;

    typedef struct packed {
        logic [sqi_pkg::OUT_KEY_W-1:0]  out_key;
        logic                           found;
        logic [sqi_pkg::STATUS_W-1:0]   status;
        logic [sqi_pkg::COUNT_W-1:0]    count;
    } queue_rsp_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    wire                           s_tready;
    logic [sqi_pkg::S_DATA_W-1:0]  s_tdata = '0;   // key[31:0], rank[35:32], zero fill
    logic [sqi_pkg::CMD_W-1:0]     s_tuser = '0;   // command[1:0]
    wire                           m_tvalid;
    logic                          m_tready = 1'b0;
    wire  [sqi_pkg::M_DATA_W-1:0]  m_tdata;        // out_key[31:0], count[36:32], zero fill
    wire  [sqi_pkg::M_USER_W-1:0]  m_tuser;        // found[0], status[2:1]

    queue_req_t requests_to_send[$];
    queue_rsp_t results_due[$];

    // shadow copy of the sorted store
    logic [sqi_pkg::KEY_WIDTH_DEF-1:0] model_keys [STORE_DEPTH];
    int                                model_count = 0;

    // request handshake seen at the last rising edge, read by the driver
    logic s_taken = 1'b0;

    int mismatch_count = 0;
    int idle_cycles = 0;

    // sender burst shaping
    int burst_left = 8;
    int gap_left = 0;
    queue_req_t next_req;

    // receiver stall pattern
    ready_mode_t ready_mode = RDY_OPEN;
    int          ready_phase_left = 0;
    int          throttle_tick = 0;

    sorted_insert_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // applies one request to the shadow store and returns the response it owes
    function automatic queue_rsp_t predict_queue_op(
        input sqi_pkg::sqi_cmd_t cmd,
        input logic [sqi_pkg::IN_KEY_W-1:0] key,
        input logic [sqi_pkg::RANK_W-1:0] rank);
        queue_rsp_t rsp;
        int         pos;
        int         i;
        rsp = '0;
        rsp.status = sqi_pkg::ST_OK;
        case (cmd)
            sqi_pkg::CMD_INSERT:
            begin
                if (model_count >= STORE_DEPTH)
                    rsp.status = sqi_pkg::ST_FULL;
                else
                begin
                    // store is ascending, so scanning down finds the first
                    // strictly greater key; equal keys stay ahead of the new one
                    pos = model_count;
                    for (i = model_count - 1; i >= 0; i--)
                        if (model_keys[i] > key)
                            pos = i;
                    for (i = model_count; i > pos; i--)
                        model_keys[i] = model_keys[i-1];
                    model_keys[pos] = key;
                    model_count++;
                end
            end
            sqi_pkg::CMD_POP:
            begin
                if (model_count == 0)
                    rsp.status = sqi_pkg::ST_EMPTY;
                else
                begin
                    rsp.out_key = model_keys[0];
                    rsp.found   = 1'b1;
                    for (i = 1; i < model_count; i++)
                        model_keys[i-1] = model_keys[i];
                    model_count--;
                end
            end
            sqi_pkg::CMD_GET:
            begin
                if (int'(rank) >= model_count)
                    rsp.status = sqi_pkg::ST_EMPTY;
                else
                begin
                    rsp.out_key = model_keys[rank];
                    rsp.found   = 1'b1;
                end
            end
            sqi_pkg::CMD_CLEAR:
                model_count = 0;
            default:
                rsp.status = sqi_pkg::ST_OK;
        endcase
        rsp.count = sqi_pkg::COUNT_W'(model_count);
        return rsp;
    endfunction

    task automatic queue_request(input sqi_pkg::sqi_cmd_t cmd,
                                 input logic [sqi_pkg::IN_KEY_W-1:0] key,
                                 input logic [sqi_pkg::RANK_W-1:0] rank,
                                 input logic hold);
        queue_req_t req;
        req.hold_until_idle = hold;
        req.cmd             = cmd;
        req.key             = key;
        req.rank            = rank;
        requests_to_send.push_back(req);
    endtask

    // driver: new request only once the current one is taken (or none is up)
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (requests_to_send.size() == 0 ||
                     (requests_to_send[0].hold_until_idle && results_due.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_req = requests_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{FILL_BITS{1'b0}}, next_req.rank, next_req.key};
                s_tuser  <= next_req.cmd;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    // mostly short bursts, now and then a long unbroken run
                    if ($urandom_range(0, 3) == 0)
                        burst_left = $urandom_range(40, 120);
                    else
                        burst_left = $urandom_range(1, 16);
                    gap_left = $urandom_range(0, 6);
                end
            end
        end
    end

    // receiver: ready pattern switches among open, random and throttled modes
    always @(negedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_phase_left = $urandom_range(20, 120);
        end
        else
            ready_phase_left = ready_phase_left - 1;
        throttle_tick = (throttle_tick + 1) % 3;
        case (ready_mode)
            RDY_OPEN:     m_tready <= 1'b1;
            RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RDY_THROTTLE: m_tready <= (throttle_tick == 0);
            default:      m_tready <= 1'b1;
        endcase
    end

    // monitor: predicts on every accepted request, checks every response
    always @(posedge clk or negedge rst_n)
    begin
        queue_rsp_t got;
        queue_rsp_t want;
        if (!rst_n)
        begin
            s_taken     <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            s_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (s_tvalid && s_tready)
                results_due.push_back(
                    predict_queue_op(sqi_pkg::sqi_cmd_t'(s_tuser),
                                     s_tdata[sqi_pkg::IN_KEY_W-1:0],
                                     s_tdata[sqi_pkg::IN_KEY_W +: sqi_pkg::RANK_W]));

            if (m_tvalid && m_tready)
            begin
                got.out_key = m_tdata[sqi_pkg::OUT_KEY_W-1:0];
                got.count   = m_tdata[sqi_pkg::OUT_KEY_W +: sqi_pkg::COUNT_W];
                got.found   = m_tuser[0];
                got.status  = m_tuser[2:1];
                if (results_due.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: response with none pending: ", $realtime,
                                 "key=%h found=%b status=%0d count=%0d",
                                 got.out_key, got.found, got.status, got.count);
                    mismatch_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("%0t: mismatch ", $realtime,
                                     "exp key=%h found=%b status=%0d count=%0d",
                                     want.out_key, want.found, want.status, want.count,
                                     " / got key=%h found=%b status=%0d count=%0d",
                                     got.out_key, got.found, got.status, got.count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int                             gen_count;
        int                             i;
        int                             pick;
        gen_phase_t                     phase;
        sqi_pkg::sqi_cmd_t              cmd;
        logic [sqi_pkg::IN_KEY_W-1:0]   key;
        logic [sqi_pkg::RANK_W-1:0]     rank;

        // directed: empty store corner cases first
        queue_request(sqi_pkg::CMD_POP, 32'h0, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_GET, 32'h0, 4'd0, 1'b0);
        // extremes and a pair of equal keys
        queue_request(sqi_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'hF, 1'b0);
        queue_request(sqi_pkg::CMD_INSERT, 32'h8000_0000, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_INSERT, 32'h0000_0000, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_INSERT, 32'h8000_0000, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_GET, 32'h0, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_GET, 32'h0, 4'd3, 1'b0);
        // rank equal to the count is out of range
        queue_request(sqi_pkg::CMD_GET, 32'hFFFF_FFFF, 4'd4, 1'b0);
        queue_request(sqi_pkg::CMD_POP, 32'h0, 4'd0, 1'b0);
        // fill to the top, then an insert that must be dropped
        for (i = 0; i < 13; i++)
            queue_request(sqi_pkg::CMD_INSERT, $urandom, 4'($urandom_range(0, 15)), 1'b0);
        queue_request(sqi_pkg::CMD_INSERT, 32'h0000_0001, 4'd0, 1'b0);
        queue_request(sqi_pkg::CMD_GET, 32'h0, 4'd15, 1'b0);
        queue_request(sqi_pkg::CMD_CLEAR, 32'h0, 4'd0, 1'b0);
        // pop right after clear sees an empty store
        queue_request(sqi_pkg::CMD_POP, 32'h0, 4'd0, 1'b1);

        // random part: phases that push the store up, down, or hover
        gen_count = 0;
        phase = PH_MIXED;
        for (i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i % 40 == 0)
                phase = gen_phase_t'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            case (phase)
                PH_FILL:
                    cmd = (pick < 60) ? sqi_pkg::CMD_INSERT :
                          (pick < 75) ? sqi_pkg::CMD_POP :
                          (pick < 97) ? sqi_pkg::CMD_GET : sqi_pkg::CMD_CLEAR;
                PH_DRAIN:
                    cmd = (pick < 20) ? sqi_pkg::CMD_INSERT :
                          (pick < 65) ? sqi_pkg::CMD_POP :
                          (pick < 97) ? sqi_pkg::CMD_GET : sqi_pkg::CMD_CLEAR;
                default:
                    cmd = (pick < 40) ? sqi_pkg::CMD_INSERT :
                          (pick < 70) ? sqi_pkg::CMD_POP :
                          (pick < 97) ? sqi_pkg::CMD_GET : sqi_pkg::CMD_CLEAR;
            endcase

            // keys: full range, a narrow range for many ties, and extremes
            case ($urandom_range(0, 3))
                1:       key = $urandom_range(0, 15);
                2:
                begin
                    case ($urandom_range(0, 3))
                        0:       key = 32'h0000_0000;
                        1:       key = 32'hFFFF_FFFF;
                        2:       key = 32'h7FFF_FFFF;
                        default: key = 32'h8000_0000;
                    endcase
                end
                default: key = $urandom;
            endcase

            // ranks mostly land inside the stored range
            if (gen_count > 0 && $urandom_range(0, 4) != 0)
                rank = sqi_pkg::RANK_W'($urandom_range(0, gen_count - 1));
            else
                rank = sqi_pkg::RANK_W'($urandom_range(0, 15));

            queue_request(cmd, key, rank, (i % 150 == 75));

            case (cmd)
                sqi_pkg::CMD_INSERT: if (gen_count < STORE_DEPTH) gen_count++;
                sqi_pkg::CMD_POP:    if (gen_count > 0) gen_count--;
                sqi_pkg::CMD_CLEAR:  gen_count = 0;
                default:             gen_count = gen_count;
            endcase
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(requests_to_send.size() == 0 && !s_tvalid && results_due.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);

        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
        end
        else
        begin
            // let any stray response show up before the verdict
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (mismatch_count == 0 && results_due.size() == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
